>>> rtl/nfpfa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// next-fit page frame allocator. No dependencies.
`timescale 1ns / 1ps

package nfpfa_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int PAGE_SIZE = 4096;

    localparam int WORD_W   = 64;                       // map bits per memory word
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int WORDS    = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PAGE_W   = WADDR_W + BIT_W;
    localparam int CNT_W    = $clog2(WORDS + 2);
    localparam int PG_SHIFT = $clog2(PAGE_SIZE);

    localparam int ADDR_W  = 32;
    localparam int INDEX_W = 12;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOF = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // write one all-ones word of the reset sweep
        logic load;     // capture an input word
        logic issue;    // read the word at the scan address
        logic publish;  // move the finished result to the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ld_skip;    // input word needs no map access
        logic scan_hit;
        logic scan_miss;
        logic scan_over;  // every word of the scan has been read
        logic rng_end;    // scan address is the last word of the range
        logic clr_end;
    } t_sts;

endpackage

>>> rtl/nfpfa_datapath.sv
// Datapath: occupancy map memory, next-fit pointer, scan address and the
// per-word allocate / free / range logic. Uses nfpfa_pkg.
`timescale 1ns / 1ps

module nfpfa_datapath import nfpfa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [INDEX_W-1:0]  i_page_index,
    input  logic [ADDR_W-1:0]   i_range_start_addr,
    input  logic [ADDR_W-1:0]   i_range_end_addr,
    output logic [INDEX_W-1:0]  o_frame_index,
    output logic [STAT_W-1:0]   o_status
);

    localparam logic [WORD_W-1:0]  ONES      = '1;
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);

    function automatic logic [BIT_W-1:0] f_encode(input logic [WORD_W-1:0] onehot);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (onehot[i]) idx = idx | BIT_W'(i);
        end
        return idx;
    endfunction

    logic [WORD_W-1:0]  r_mem [WORDS];

    logic [PAGE_W-1:0]  r_ptr;
    logic [WADDR_W-1:0] r_iaddr;
    logic [CNT_W-1:0]   r_icnt;
    logic               r_rd_vld;
    logic [WORD_W-1:0]  r_rd_data;
    logic [WADDR_W-1:0] r_rd_addr;
    logic [CNT_W-1:0]   r_rd_cnt;
    logic [OP_W-1:0]    r_op;
    logic [BIT_W-1:0]   r_page_bit;
    logic [PAGE_W-1:0]  r_spg;
    logic [PAGE_W-1:0]  r_epg;
    logic [INDEX_W-1:0] r_frame;
    logic [STAT_W-1:0]  r_status;
    logic [INDEX_W-1:0] r_out_frame;
    logic [STAT_W-1:0]  r_out_status;

    // load-side decode
    logic [ADDR_W-1:0]  s_pg32, e_pg32, e_clamp, f_pg32;
    logic               rng_ok, free_bad;
    logic [PAGE_W-1:0]  f_pg, s_pg;

    // evaluation of the word read last cycle
    logic [WORD_W-1:0]  low_mask, scan_mask, free_bits, iso;
    logic [BIT_W-1:0]   hit_idx;
    logic               any_free, scan_hit, scan_miss, fbit;
    logic [WORD_W-1:0]  fmask, lo_mask, hi_mask;
    logic [PAGE_W-1:0]  hit_page;

    logic               w_en;
    logic [WADDR_W-1:0] w_addr;
    logic [WORD_W-1:0]  w_data;
    logic [WADDR_W-1:0] iaddr_inc;

    always_comb begin
        s_pg32   = i_range_start_addr >> PG_SHIFT;
        e_pg32   = i_range_end_addr >> PG_SHIFT;
        // start below map and start <= raw end is the same test as against clamped end
        rng_ok   = (s_pg32 < ADDR_W'(NUM_PAGES)) && (s_pg32 <= e_pg32);
        e_clamp  = (e_pg32 > ADDR_W'(NUM_PAGES - 1)) ? ADDR_W'(NUM_PAGES - 1) : e_pg32;
        f_pg32   = ADDR_W'(i_page_index);
        free_bad = f_pg32 >= ADDR_W'(NUM_PAGES);
        f_pg     = PAGE_W'(f_pg32);
        s_pg     = PAGE_W'(s_pg32);
    end

    assign iaddr_inc = (r_iaddr == LAST_WORD) ? '0 : r_iaddr + 1'b1;

    always_comb begin
        low_mask  = ONES << r_ptr[BIT_W-1:0];
        if (r_rd_cnt == '0) begin
            scan_mask = low_mask;
        end else if (r_rd_cnt == CNT_W'(WORDS)) begin
            scan_mask = ~low_mask;          // wrapped back to the pointer word
        end else begin
            scan_mask = ONES;
        end
        free_bits = ~r_rd_data & scan_mask;
        iso       = free_bits & (~free_bits + WORD_W'(1));
        hit_idx   = f_encode(iso);
        hit_page  = {r_rd_addr, hit_idx};
        any_free  = |free_bits;
        scan_hit  = r_rd_vld && (r_op == OP_ALLOC) && any_free;
        scan_miss = r_rd_vld && (r_op == OP_ALLOC) && !any_free
                    && (r_rd_cnt == CNT_W'(WORDS));

        fbit  = r_rd_data[r_page_bit];
        fmask = WORD_W'(1) << r_page_bit;

        lo_mask = (r_rd_addr == r_spg[PAGE_W-1:BIT_W]) ? (ONES << r_spg[BIT_W-1:0]) : ONES;
        hi_mask = (r_rd_addr == r_epg[PAGE_W-1:BIT_W])
                  ? (ONES >> (BIT_W'(WORD_W - 1) - r_epg[BIT_W-1:0])) : ONES;
    end

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_rd_addr;
        w_data = r_rd_data;
        if (i_cmd.clr) begin
            w_en   = 1'b1;
            w_addr = r_iaddr;
            w_data = ONES;
        end else if (r_rd_vld) begin
            case (r_op)
                OP_ALLOC: begin
                    w_en   = any_free;
                    w_data = r_rd_data | iso;
                end
                OP_FREE: begin
                    w_en   = fbit;
                    w_data = r_rd_data & ~fmask;
                end
                OP_RANGE: begin
                    w_en   = 1'b1;
                    w_data = r_rd_data & ~(lo_mask & hi_mask);
                end
                default: begin
                    w_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_iaddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_iaddr  <= '0;
            r_icnt   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (scan_hit) begin
                r_ptr <= hit_page;
            end
            if (i_cmd.load) begin
                r_icnt <= '0;
                case (i_opcode)
                    OP_ALLOC: r_iaddr <= r_ptr[PAGE_W-1:BIT_W];
                    OP_FREE:  r_iaddr <= f_pg[PAGE_W-1:BIT_W];
                    OP_RANGE: r_iaddr <= s_pg[PAGE_W-1:BIT_W];
                    default:  r_iaddr <= r_iaddr;
                endcase
            end else if (i_cmd.issue) begin
                r_iaddr <= iaddr_inc;
                r_icnt  <= r_icnt + 1'b1;
            end else if (i_cmd.clr) begin
                r_iaddr <= iaddr_inc;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_addr <= r_iaddr;
            r_rd_cnt  <= r_icnt;
        end
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_page_bit <= f_pg[BIT_W-1:0];
            r_spg      <= s_pg;
            r_epg      <= PAGE_W'(e_clamp);
            r_frame    <= '0;
            r_status   <= ((i_opcode == OP_FREE) && free_bad) ? ST_BAD : ST_OK;
        end else begin
            if (scan_hit) begin
                r_frame <= INDEX_W'(hit_page);
            end
            if (scan_miss) begin
                r_status <= ST_OOF;
            end
            if (r_rd_vld && (r_op == OP_FREE) && !fbit) begin
                r_status <= ST_BAD;     // double free
            end
        end
        if (i_cmd.publish) begin
            r_out_frame  <= r_frame;
            r_out_status <= r_status;
        end
    end

    always_comb begin
        o_sts.ld_skip   = ((i_opcode == OP_FREE) && free_bad)
                          || ((i_opcode == OP_RANGE) && !rng_ok);
        o_sts.scan_hit  = scan_hit;
        o_sts.scan_miss = scan_miss;
        o_sts.scan_over = r_icnt > CNT_W'(WORDS);
        o_sts.rng_end   = r_iaddr == r_epg[PAGE_W-1:BIT_W];
        o_sts.clr_end   = r_iaddr == LAST_WORD;
    end

    assign o_frame_index = r_out_frame;
    assign o_status      = r_out_status;

endmodule

>>> rtl/nfpfa_ctrl.sv
// Controller: sequences reset sweep, allocate scan, free and range release,
// and owns both handshakes. Uses nfpfa_pkg.
`timescale 1ns / 1ps

module nfpfa_ctrl import nfpfa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [OP_W-1:0] i_opcode,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_cmd            o_cmd,
    input  t_sts            i_sts
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_FREE_RD  = 3'd3;
    localparam logic [2:0] S_FREE_CHK = 3'd4;
    localparam logic [2:0] S_RNG      = 3'd5;
    localparam logic [2:0] S_RNG_LAST = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_ovld;

    always_comb begin
        o_cmd.clr     = (r_state == S_CLEAR);
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.issue   = ((r_state == S_SCAN) && !i_sts.scan_over && !i_sts.scan_hit)
                        || (r_state == S_FREE_RD) || (r_state == S_RNG);
        o_cmd.publish = (r_state == S_DONE) && (!r_ovld || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.ld_skip) begin
                        n_state = S_DONE;
                    end else begin
                        case (i_opcode)
                            OP_ALLOC: n_state = S_SCAN;
                            OP_FREE:  n_state = S_FREE_RD;
                            OP_RANGE: n_state = S_RNG;
                            default:  n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_hit || i_sts.scan_miss) n_state = S_DONE;
            end
            S_FREE_RD:  n_state = S_FREE_CHK;
            S_FREE_CHK: n_state = S_DONE;
            S_RNG: begin
                if (i_sts.rng_end) n_state = S_RNG_LAST;
            end
            S_RNG_LAST: n_state = S_DONE;
            S_DONE: begin
                if (o_cmd.publish) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.publish) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;

endmodule

>>> rtl/next_fit_page_frame_allocator.sv
// Channel  Handshake               Payload
// in       i_in_valid/o_in_ready   i_opcode, i_page_index, i_range_start_addr,
//                                  i_range_end_addr
// out      o_out_valid/i_out_ready o_frame_index, o_status
//
// Map access: allocate reads one map word per cycle from the single read port,
// from the pointer word round to it again; free reads one word; range release
// reads each word covered; skipped ranges, bad frees and unused opcodes read none.
// Reset: a sweep writes every map word to all ones, with in_ready low. A
// pending result sits in the output register; the next word is taken
// meanwhile and waits only at completion if the output is still full.
//
// Top level: controller plus datapath. Uses nfpfa_pkg.
`timescale 1ns / 1ps

module next_fit_page_frame_allocator import nfpfa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [INDEX_W-1:0]  i_page_index,
    input  logic [ADDR_W-1:0]   i_range_start_addr,
    input  logic [ADDR_W-1:0]   i_range_end_addr,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [INDEX_W-1:0]  o_frame_index,
    output logic [STAT_W-1:0]   o_status
);

    t_cmd cmd;
    t_sts sts;

    nfpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    nfpfa_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_opcode           (i_opcode),
        .i_page_index       (i_page_index),
        .i_range_start_addr (i_range_start_addr),
        .i_range_end_addr   (i_range_end_addr),
        .o_frame_index      (o_frame_index),
        .o_status           (o_status)
    );

endmodule

>>> rtl/nfpfa_checker.sv
// Port-level checks for the allocator, bound to the top level.
// Uses nfpfa_pkg for status codes.
`timescale 1ns / 1ps

module nfpfa_port_checker import nfpfa_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [INDEX_W-1:0]  o_frame_index,
    input logic [STAT_W-1:0]   o_status
);

    // output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_index)
        && $stable(o_status))
        else $error("output word changed while stalled");

    // failed operations never report a frame
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_frame_index == '0)
        && ((o_status == ST_OOF) || (o_status == ST_BAD)))
        else $error("bad status or nonzero frame on failure");

    // map sweep after reset keeps input closed
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready or valid right after reset");

    // input closes once a word is taken
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken on consecutive cycles");

endmodule

bind next_fit_page_frame_allocator nfpfa_port_checker u_nfpfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_frame_index (o_frame_index),
    .o_status      (o_status)
);

>>> tb/nfpfa_checker.sv
// Checker for the next-fit page frame allocator: watches both channels, keeps
// its own occupancy map and next-fit cursor, and compares every result word.
// Uses nfpfa_pkg.
`timescale 1ns / 1ps

module nfpfa_checker import nfpfa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [INDEX_W-1:0]  i_page_index,
    input  logic [ADDR_W-1:0]   i_range_start_addr,
    input  logic [ADDR_W-1:0]   i_range_end_addr,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [INDEX_W-1:0]  i_frame_index,
    input  logic [STAT_W-1:0]   i_status,
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [INDEX_W-1:0] frame;
        logic [STAT_W-1:0]  status;
    } t_reply;

    localparam int PRINT_CAP = 50;

    logic [NUM_PAGES-1:0] page_taken;   // set bit: frame in use
    int                   fit_cursor;
    t_reply               owed_replies[$];
    int                   mismatches = 0;

    assign o_fail_count = mismatches;

    initial o_pending = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Applies one request word to the map and returns the reply it owes.
    function automatic t_reply apply_request(input logic [OP_W-1:0]    op,
                                             input logic [INDEX_W-1:0] idx,
                                             input logic [ADDR_W-1:0]  start_addr,
                                             input logic [ADDR_W-1:0]  end_addr);
        t_reply r;
        int     p;
        int     found;
        bit     hit;
        longint first_pg;
        longint last_pg;
        r.frame  = '0;
        r.status = ST_OK;
        hit      = 0;
        found    = 0;
        case (op)
            OP_ALLOC: begin
                // cursor to top, then wrap to below the cursor
                for (p = fit_cursor; p < NUM_PAGES && !hit; p++) begin
                    if (!page_taken[p]) begin
                        hit   = 1;
                        found = p;
                    end
                end
                for (p = 0; p < fit_cursor && !hit; p++) begin
                    if (!page_taken[p]) begin
                        hit   = 1;
                        found = p;
                    end
                end
                if (hit) begin
                    page_taken[found] = 1'b1;
                    fit_cursor        = found;
                    r.frame           = found[INDEX_W-1:0];
                end else begin
                    r.status = ST_OOF;
                end
            end
            OP_FREE: begin
                p = int'(idx);
                if (p >= NUM_PAGES || !page_taken[p])
                    r.status = ST_BAD;
                else
                    page_taken[p] = 1'b0;
            end
            OP_RANGE: begin
                first_pg = longint'(start_addr) / PAGE_SIZE;
                last_pg  = longint'(end_addr) / PAGE_SIZE;
                if (last_pg > NUM_PAGES - 1)
                    last_pg = NUM_PAGES - 1;
                if (first_pg < NUM_PAGES && first_pg <= last_pg) begin
                    for (p = int'(first_pg); p <= int'(last_pg); p++)
                        page_taken[p] = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_reply want;
        if (!i_rst_n) begin
            page_taken = '1;
            fit_cursor = 0;
            owed_replies.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                owed_replies.push_back(apply_request(i_opcode, i_page_index,
                                                     i_range_start_addr, i_range_end_addr));
            if (i_out_valid && i_out_ready) begin
                if (owed_replies.size() == 0) begin
                    report_mismatch("result word with none owed, status",
                                    int'(i_status), -1);
                end else begin
                    want = owed_replies.pop_front();
                    if (i_frame_index !== want.frame)
                        report_mismatch("frame_index", int'(i_frame_index), int'(want.frame));
                    if (i_status !== want.status)
                        report_mismatch("status", int'(i_status), int'(want.status));
                end
            end
        end
        o_pending <= owed_replies.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the allocator testbench: clock, reset, request stimulus, result sink
// with stalls, and the verdict. Uses nfpfa_pkg, nfpfa_checker and the block.
`timescale 1ns / 1ps

module testbench;
    import nfpfa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int TOTAL_WORDS  = 1450;
    localparam int TAIL_WORDS   = 150;     // no idling on either side here
    localparam int STALL_LIMIT  = 4000;    // cycles with nothing accepted
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 100;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               in_valid      = 1'b0;
    logic [OP_W-1:0]    opcode        = '0;
    logic [INDEX_W-1:0] page_index    = '0;
    logic [ADDR_W-1:0]  range_start   = '0;
    logic [ADDR_W-1:0]  range_end     = '0;
    logic               out_ready     = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [INDEX_W-1:0] frame_index;
    logic [STAT_W-1:0]  status;

    int fail_count;
    int pending;
    int words_sent   = 0;
    int stall_cycles = 0;
    bit src_idle     = 0;
    bit sink_idle    = 0;
    bit sink_hold_req = 0;

    next_fit_page_frame_allocator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_opcode           (opcode),
        .i_page_index       (page_index),
        .i_range_start_addr (range_start),
        .i_range_end_addr   (range_end),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_frame_index      (frame_index),
        .o_status           (status)
    );

    nfpfa_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_opcode           (opcode),
        .i_page_index       (page_index),
        .i_range_start_addr (range_start),
        .i_range_end_addr   (range_end),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_frame_index      (frame_index),
        .i_status           (status),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offers one request word and returns at the edge where it is taken.
    task automatic send_word(input logic [OP_W-1:0]    op,
                             input logic [INDEX_W-1:0] idx,
                             input logic [ADDR_W-1:0]  start_addr,
                             input logic [ADDR_W-1:0]  end_addr);
        int gap;
        gap = 0;
        if (src_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        page_index  <= idx;
        range_start <= start_addr;
        range_end   <= end_addr;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_alloc();
        send_word(OP_ALLOC, INDEX_W'($urandom), $urandom, $urandom);
    endtask

    task automatic send_free(input int pg);
        send_word(OP_FREE, pg[INDEX_W-1:0], $urandom, $urandom);
    endtask

    // drop valid first so the last word is not taken twice;
    // pending is a registered copy of the checker's queue, so let it update first
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Some address inside page pg.
    function automatic logic [ADDR_W-1:0] page_addr(input int pg);
        return pg * PAGE_SIZE + $urandom_range(0, PAGE_SIZE - 1);
    endfunction

    // Result sink: random stall bursts, one long hold on request.
    initial begin : sink_proc
        int n;
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (sink_idle && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 15);
                out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int  base;
        int  span;
        int  allocs_left;
        bit  mid_drain_done;
        mid_drain_done = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every frame starts occupied
        send_alloc();                                   // out of frames
        send_free(0);
        send_free(NUM_PAGES - 1);
        send_free(NUM_PAGES - 1);                       // double free
        send_alloc();                                   // frame 0
        send_alloc();                                   // top frame
        send_alloc();                                   // wraps, full again
        send_free(NUM_PAGES - 1);                       // free an allocated frame
        // reversed
        send_word(OP_RANGE, INDEX_W'($urandom), 32'hFFFF_FFFF, 32'h0000_0000);
        // starts past map
        send_word(OP_RANGE, INDEX_W'($urandom), 32'hFFFF_F000, 32'hFFFF_FFFF);
        // clamped
        send_word(OP_RANGE, INDEX_W'($urandom), page_addr(NUM_PAGES - 6), 32'hFFFF_FFFF);
        send_word(OP_UNUSED, INDEX_W'($urandom), $urandom, $urandom);
        send_alloc();
        send_alloc();
        // inside one page
        send_word(OP_RANGE, INDEX_W'($urandom), 32'h0000_1234, 32'h0000_1FFF);
        send_word(OP_RANGE, INDEX_W'($urandom), 32'h0000_0000, 32'h0000_0000);
        repeat (6) send_alloc();                        // runs up to the top, wraps to 0, 1
        send_alloc();                                   // out of frames
        wait_for_results();

        // backpressure: sink holds off while requests keep coming
        sink_hold_req = 1;
        repeat (24) send_free($urandom_range(0, NUM_PAGES - 1));
        wait_for_results();

        while (words_sent < TOTAL_WORDS) begin
            if (words_sent >= TOTAL_WORDS - TAIL_WORDS) begin
                src_idle  = 0;
                sink_idle = 0;
            end else begin
                src_idle  = $urandom_range(0, 2) != 0;
                sink_idle = $urandom_range(0, 2) != 0;
            end
            if (!mid_drain_done && words_sent >= TOTAL_WORDS / 2) begin
                wait_for_results();
                mid_drain_done = 1;
            end
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4))
                    send_word(OP_W'($urandom_range(OP_ALLOC, OP_UNUSED)),
                              INDEX_W'($urandom), $urandom, $urandom);
            end else begin
                // release a small block, then allocate it back with frees mixed in;
                // each free asks for one more allocate so the map often runs out
                base = $urandom_range(0, NUM_PAGES - 1);
                span = $urandom_range(1, 40);
                send_word(OP_RANGE, INDEX_W'($urandom), page_addr(base),
                          page_addr(base + span - 1));
                allocs_left = span + $urandom_range(0, 3);
                while (allocs_left > 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_free(base + $urandom_range(0, span + 3));
                        allocs_left++;
                    end else begin
                        send_alloc();
                        allocs_left--;
                    end
                end
            end
        end

        in_valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
